// ===== rtl/core/ttw_pkg.sv =====
package ttw_pkg;

  // Field widths fixed by the interface
  localparam int POS_W  = 11;
  localparam int IDX_W  = 11;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  // Compare width wide enough for the largest store
  localparam int CMP_W  = 16;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_TILDE = 8'h7E;

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

  // Operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [CHAR_W-1:0] char_byte;
    logic              control_mode;
    logic [IDX_W-1:0]  cell_index;
  } in_beat_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attr;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic clear_step;
    logic copy_step;
    logic blank_step;
    logic out_load;
  } ttw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_clear;
    logic need_scroll;
    logic sweep_end;
    logic copy_end;
    logic out_free;
  } ttw_status_t;

endpackage

// ===== rtl/core/ttw_ram.sv =====
module ttw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/ttw_datapath.sv =====
module ttw_datapath
  import ttw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  in_beat_t          in_beat,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data,
  input  logic              out_stall,
  output logic              out_valid,
  output out_beat_t         out_beat,
  input  ttw_cmd_t          cmd,
  output ttw_status_t       status
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam logic [ADDR_W-1:0] STEP      = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(COLUMNS * (ROWS - 1));
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COLUMNS * (ROWS - 1) - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  // Architectural state
  logic [ATTR_W-1:0] attr;
  logic [ATTR_W-1:0] fill_attr;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] row_base;   // cursor row times COLUMNS
  logic              locked;

  // Item and sweep registers
  in_beat_t          item;
  logic [ADDR_W-1:0] cnt;
  logic              pend_valid;
  logic [ADDR_W-1:0] pend_addr;

  // Cell store ports
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_wr_addr;
  logic [ATTR_W+CHAR_W-1:0]   ram_wr_data;
  logic [ADDR_W-1:0]          ram_rd_addr;
  logic [ATTR_W+CHAR_W-1:0]   ram_rd_data;

  // Item decode
  logic              is_write, is_ff, is_bs, is_nl, is_print;
  logic              at_last_row, col_last, row_adv, bs_back, rd_in_range;
  logic [CHAR_W-1:0] print_char;
  logic [ADDR_W-1:0] cur_addr, bs_addr, pos_full;

  always_comb begin
    is_write    = item.op == OP_WRITE;
    is_ff       = item.control_mode && (item.char_byte == CH_FF);
    is_bs       = item.control_mode && (item.char_byte == CH_BS);
    is_nl       = (item.char_byte == CH_LF) || (item.char_byte == CH_CR);
    is_print    = !is_ff && !is_bs && !is_nl;
    at_last_row = row_base == LAST_BASE;
    col_last    = col == COL_LAST;
    row_adv     = is_nl || (is_print && col_last);
    bs_back     = (col != '0) || (!locked && (row_base != '0));
    cur_addr    = row_base + ADDR_W'(col);
    bs_addr     = bs_back ? cur_addr - ADDR_W'(1) : cur_addr;
    print_char  = ((item.char_byte >= CH_SPACE) && (item.char_byte <= CH_TILDE)) ?
                  item.char_byte : CH_DOT;
    rd_in_range = CMP_W'(item.cell_index) < CMP_W'(CELLS);
    pos_full    = row_base + ADDR_W'(col);
  end

  // Status back to the controller
  always_comb begin
    status.need_clear  = is_write && is_ff;
    status.need_scroll = is_write && row_adv && at_last_row;
    status.sweep_end   = cnt == LAST_CELL;
    status.copy_end    = cnt == COPY_LAST;
    status.out_free    = !out_valid || !out_stall;
  end

  // Write port: item write, clear, scroll copy, then scroll blank
  always_comb begin
    ram_we      = 1'b0;
    ram_wr_addr = cnt;
    ram_wr_data = {fill_attr, CH_SPACE};
    if (cmd.exec && is_write && is_print) begin
      ram_we      = 1'b1;
      ram_wr_addr = cur_addr;
      ram_wr_data = {attr, print_char};
    end else if (cmd.exec && is_write && is_bs) begin
      ram_we      = 1'b1;
      ram_wr_addr = bs_addr;
      ram_wr_data = {attr, CH_NUL};
    end else if (cmd.clear_step) begin
      ram_we      = 1'b1;
    end else if (pend_valid) begin
      ram_we      = 1'b1;
      ram_wr_addr = pend_addr;
      ram_wr_data = ram_rd_data;
    end else if (cmd.blank_step) begin
      ram_we      = 1'b1;
      ram_wr_data = {attr, CH_NUL};
    end
  end

  // Read port: one row ahead while copying, else the item's cell
  assign ram_rd_addr = cmd.copy_step ? cnt + STEP : ADDR_W'(item.cell_index);

  ttw_ram #(
    .WIDTH (ATTR_W + CHAR_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Cursor, attribute and sweep control
  always_ff @(posedge clk) begin
    if (rst) begin
      attr       <= RESET_ATTR;
      fill_attr  <= RESET_ATTR;
      col        <= '0;
      row_base   <= '0;
      locked     <= 1'b1;
      cnt        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        attr <= cfg_wr_data;
      end
      if (cmd.exec && is_write) begin
        if (is_ff) begin
          col       <= '0;
          row_base  <= '0;
          locked    <= 1'b1;
          fill_attr <= attr;
        end else if (is_bs) begin
          if (col != '0) begin
            col <= col - COL_W'(1);
          end else if (!locked && (row_base != '0)) begin
            row_base <= row_base - STEP;
            col      <= COL_LAST;
          end
        end else if (row_adv) begin
          col    <= '0;
          locked <= is_nl;
          if (!at_last_row) begin
            row_base <= row_base + STEP;
          end
        end else begin
          col <= col + COL_W'(1);
        end
      end
      // shared sweep counter: clear, copy, then blank continues from the last row
      if (cmd.exec) begin
        cnt <= '0;
      end else if (cmd.clear_step || cmd.copy_step || cmd.blank_step) begin
        cnt <= cnt + ADDR_W'(1);
      end
      pend_valid <= cmd.copy_step;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_beat;
    end
    pend_addr <= cnt;
    if (cmd.out_load) begin
      out_beat.cursor_position <= POS_W'(pos_full);
      if (!is_write && rd_in_range) begin
        out_beat.cell_char <= ram_rd_data[CHAR_W-1:0];
        out_beat.cell_attr <= ram_rd_data[ATTR_W+CHAR_W-1:CHAR_W];
      end else begin
        out_beat.cell_char <= '0;
        out_beat.cell_attr <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/ttw_ctrl.sv =====
module ttw_ctrl
  import ttw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ttw_status_t status,
  output ttw_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT:  if (status.sweep_end) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (status.need_clear) begin
          state_next = ST_CLEAR;
        end else if (status.need_scroll) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: if (status.sweep_end) state_next = ST_DONE;
      ST_COPY:  if (status.copy_end) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_BLANK;
      ST_BLANK: if (status.sweep_end) state_next = ST_DONE;
      ST_DONE:  if (status.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_INIT, ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_EXEC:  cmd.exec       = 1'b1;
      ST_COPY:  cmd.copy_step  = 1'b1;
      ST_DRAIN: cmd            = '0;
      ST_BLANK: cmd.blank_step = 1'b1;
      ST_DONE:  cmd.out_load   = status.out_free;
      default:  cmd            = '0;
    endcase
  end

  // An accepted beat goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> state == ST_EXEC)
    else $error("accepted beat did not enter execution");

  // Every item reaches a result before the next one is taken
  a_exec_no_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC |=> state != ST_IDLE)
    else $error("item dropped without a result");

  // Scroll copy drains its pending write before blanking
  a_copy_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY && status.copy_end) |=> state == ST_DRAIN ##1 state == ST_BLANK)
    else $error("scroll sequence broken");

  // At most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.exec, cmd.clear_step, cmd.copy_step, cmd.blank_step}))
    else $error("conflicting datapath commands");

endmodule

// ===== rtl/core/text_terminal_writer.sv =====
// Sequence: a read or an ordinary write beat is executed and its result loaded into the output register;
//   a new line or wrap on the last row first copies the rows up and then blanks the last row,
//   a form feed first clears the whole store; all go through the single cell store write port.
// No new beat is accepted until the previous result is loaded; results wait in an output register.
// Reset: synchronous, active high; afterwards the store is filled with spaces, and no beat is
//   accepted until the fill is done.
module text_terminal_writer
  import ttw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_beat_t          in_beat,
  output logic              out_valid,
  input  logic              out_stall,
  output out_beat_t         out_beat,
  input  logic              cfg_wr_en,
  input  logic [ATTR_W-1:0] cfg_wr_data
);

  ttw_cmd_t    cmd;
  ttw_status_t status;

  ttw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ttw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_beat     (in_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_beat    (out_beat),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// ===== tb/sv/text_terminal_writer_tb.sv =====
module text_terminal_writer_tb;
  import ttw_pkg::*;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int IDX_TOP    = (1 << IDX_W) - 1;
  localparam int PHASES     = 9;
  localparam int PHASE_LEN  = 135;
  localparam int HOLD_LEN   = 500;
  localparam int STALL_MAX  = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_beat_t          in_beat = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_beat;
  logic              cfg_wr_en = 1'b0;
  logic [ATTR_W-1:0] cfg_wr_data = '0;

  wire in_take  = in_valid && !in_stall;
  wire out_take = out_valid && !out_stall;

  text_terminal_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_beat(in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat(out_beat),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Shadow of the terminal: cell store, cursor, line lock, attribute
  logic [ATTR_W+CHAR_W-1:0] screen [CELLS];
  int unsigned       cur_col;
  int unsigned       cur_row;
  bit                line_locked;
  logic [ATTR_W-1:0] text_attr;

  in_beat_t  char_stream[$];
  out_beat_t expected_reports[$];

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 6;
  int unsigned fault_count = 0;
  int unsigned reports_seen = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  // Stimulus-side cursor estimate, used to bound the number of scrolls
  int unsigned gen_col;
  int unsigned gen_row;
  int unsigned scrolls_left;
  int unsigned items_sent = 0;

  function automatic void put_char(int unsigned idx, logic [CHAR_W-1:0] ch);
    if (idx < CELLS) screen[idx] = {text_attr, ch};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) put_char(i, CH_SPACE);
    cur_col = 0;
    cur_row = 0;
    line_locked = 1'b1;
  endfunction

  // Row advance; past the bottom the store moves up and the last row is nulled
  function automatic void advance_row();
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < COLUMNS * (ROWS - 1); i++) screen[i] = screen[i + COLUMNS];
      for (int i = COLUMNS * (ROWS - 1); i < CELLS; i++) put_char(i, CH_NUL);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic void start_line();
    line_locked = 1'b1;
    cur_col = 0;
    advance_row();
  endfunction

  function automatic out_beat_t terminal_step(in_beat_t b);
    out_beat_t         r;
    logic [CHAR_W-1:0] ch;
    r = '0;
    ch = b.char_byte;
    if (b.op == OP_READ) begin
      if (b.cell_index < CELLS) begin
        r.cell_char = screen[b.cell_index][CHAR_W-1:0];
        r.cell_attr = screen[b.cell_index][ATTR_W+CHAR_W-1:CHAR_W];
      end
    end else if (b.control_mode && ch == CH_LF) begin
      start_line();
    end else if (b.control_mode && ch == CH_BS) begin
      // climb only after a wrap, never above row 0
      if (cur_col > 0) begin
        cur_col--;
      end else if (!line_locked && cur_row > 0) begin
        cur_row--;
        cur_col = COLUMNS - 1;
      end
      put_char(cur_row * COLUMNS + cur_col, CH_NUL);
    end else if (b.control_mode && ch == CH_FF) begin
      blank_screen();
    end else if (ch == CH_LF || ch == CH_CR) begin
      start_line();
    end else begin
      if (ch < CH_SPACE || ch > CH_TILDE) ch = CH_DOT;
      put_char(cur_row * COLUMNS + cur_col, ch);
      cur_col++;
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        line_locked = 1'b0;
        advance_row();
      end
    end
    r.cursor_position = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  function automatic void count_row();
    if (gen_row < ROWS - 1) gen_row++;
    else if (scrolls_left > 0) scrolls_left--;
  endfunction

  task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch, input logic ctl,
                           input logic [IDX_W-1:0] idx);
    in_beat_t b;
    b.op = op;
    b.char_byte = ch;
    b.control_mode = ctl;
    b.cell_index = idx;
    char_stream.push_back(b);
    items_sent++;
    if (op == OP_WRITE) begin
      if (ctl && ch == CH_FF) begin
        gen_col = 0;
        gen_row = 0;
      end else if (ctl && ch == CH_BS) begin
        if (gen_col > 0) gen_col--;
      end else if (ch == CH_LF || ch == CH_CR) begin
        gen_col = 0;
        count_row();
      end else begin
        gen_col++;
        if (gen_col >= COLUMNS) begin
          gen_col = 0;
          count_row();
        end
      end
    end
  endtask

  task automatic send_write(input logic [CHAR_W-1:0] ch, input logic ctl);
    send_item(OP_WRITE, ch, ctl, IDX_W'($urandom_range(IDX_TOP)));
  endtask

  task automatic send_read(input logic [IDX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom_range(255)), 1'($urandom_range(1)), idx);
  endtask

  // Mostly near the cursor or on the bottom row; some past the end of the store
  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned r;
    int unsigned at;
    r = $urandom_range(99);
    at = gen_row * COLUMNS + gen_col;
    if (r < 45) return IDX_W'((at >= 2) ? at - $urandom_range(2) : at);
    if (r < 60) return IDX_W'((ROWS - 1) * COLUMNS + $urandom_range(COLUMNS - 1));
    if (r < 88) return IDX_W'($urandom_range(CELLS - 1));
    return IDX_W'($urandom_range(IDX_TOP, CELLS));
  endfunction

  // Random text traffic: lines, line feed runs, backspaces, reads, noise, clears
  task automatic fill_phase(input int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    int unsigned r;
    target = items_sent + count;
    while (items_sent < target) begin
      if (gen_row == ROWS - 1 && scrolls_left == 0) send_write(CH_FF, 1'b1);
      pick = $urandom_range(99);
      if (pick < 45) begin
        // text line, sometimes long enough to wrap exactly at the edge or beyond
        if ($urandom_range(99) < 20)
          len = COLUMNS - gen_col + ($urandom_range(1) ? 0 : $urandom_range(COLUMNS));
        else
          len = $urandom_range(40);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 10) send_read(pick_index());
          else if (r < 18) send_write(CHAR_W'($urandom_range(255)), 1'b0);
          else send_write(CHAR_W'($urandom_range(CH_TILDE, CH_SPACE)),
                          1'($urandom_range(1)));
        end
        r = $urandom_range(99);
        if (r < 45) send_write(CH_LF, 1'b1);
        else if (r < 60) send_write(CH_CR, 1'($urandom_range(1)));
        else if (r < 70) send_write(CH_LF, 1'b0);
        else if (gen_col == 0) repeat ($urandom_range(3, 1)) send_write(CH_BS, 1'b1);
      end else if (pick < 55) begin
        repeat ($urandom_range(30, 1)) begin
          if (gen_row == ROWS - 1 && scrolls_left == 0) send_write(CH_FF, 1'b1);
          send_write($urandom_range(1) ? CH_LF : CH_CR, 1'($urandom_range(1)));
        end
      end else if (pick < 67) begin
        len = ($urandom_range(99) < 80) ? $urandom_range(6, 1) : $urandom_range(90, 60);
        repeat (len) begin
          if ($urandom_range(99) < 10) send_read(pick_index());
          send_write(CH_BS, 1'b1);
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(8, 1)) send_read(pick_index());
      end else if (pick < 96) begin
        repeat ($urandom_range(4, 1))
          send_item(1'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                    1'($urandom_range(1)), IDX_W'($urandom_range(IDX_TOP)));
      end else begin
        send_write(CH_FF, ($urandom_range(99) < 70));
      end
    end
  endtask

  // Waits until the block has nothing in flight
  task automatic wait_idle();
    while (char_stream.size() != 0 || in_valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Input driver: predicts each accepted beat, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_take) expected_reports.push_back(terminal_step(in_beat));
      if (!in_valid || !in_stall) begin
        if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_beat <= char_stream.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input int unsigned exp, input int unsigned got);
    fault_count++;
    $display("%0t: %s expected %0d got %0d", $time, name, exp, got);
  endtask

  // Output monitor: checks each result beat; long hold-offs to back up the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_take) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          fault_count++;
          $display("%0t: result beat with nothing expected, got pos %0d char %0d attr %0d",
                   $time, out_beat.cursor_position, out_beat.cell_char, out_beat.cell_attr);
        end else begin
          out_beat_t exp;
          exp = expected_reports.pop_front();
          if (out_beat.cursor_position !== exp.cursor_position)
            report_field("cursor_position", exp.cursor_position, out_beat.cursor_position);
          if (out_beat.cell_char !== exp.cell_char)
            report_field("cell_char", exp.cell_char, out_beat.cell_char);
          if (out_beat.cell_attr !== exp.cell_attr)
            report_field("cell_attr", exp.cell_attr, out_beat.cell_attr);
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (out_take && (reports_seen == 400 || reports_seen == 1000)) begin
        out_stall <= 1'b1;
        hold_left <= HOLD_LEN;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (rst || in_take || out_take) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [ATTR_W-1:0] attr;
    text_attr = RESET_ATTR;
    blank_screen();
    gen_col = 0;
    gen_row = 0;
    scrolls_left = 4;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset contents, read bounds, byte classes, commands vs plain bytes
    send_read(0);
    send_read(IDX_W'(CELLS - 1));
    send_read(IDX_W'(CELLS));
    send_read(IDX_W'(IDX_TOP));
    send_write(8'h41, 1'b0);
    send_write(CH_TILDE, 1'b1);
    send_write(CH_SPACE, 1'b0);
    send_write(8'h1F, 1'b0);
    send_write(8'h7F, 1'b1);
    send_write(8'hFF, 1'b0);
    send_write(CH_NUL, 1'b1);
    send_write(CH_BS, 1'b0);
    send_write(CH_FF, 1'b0);
    send_write(CH_BS, 1'b1);
    send_read(6);
    send_write(CH_LF, 1'b0);
    send_write(CH_BS, 1'b1);
    send_write(CH_CR, 1'b1);
    send_write(CH_LF, 1'b1);
    send_read(IDX_W'(COLUMNS));
    send_write(CH_FF, 1'b1);
    send_write(CH_BS, 1'b1);
    send_read(0);
    send_read(1);
    wait_idle();

    // Random phases, each under its own attribute; drained in between
    for (int ph = 0; ph < PHASES; ph++) begin
      attr = (ph == 0) ? 8'h00 : (ph == 1) ? 8'hFF : ATTR_W'($urandom_range(255));
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= attr;
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      text_attr = attr;
      @(negedge clk);
      send_idle_pct = (ph == 4) ? 0 : 6;
      recv_idle_pct = (ph == 4) ? 0 : 6;
      gen_col = cur_col;
      gen_row = cur_row;
      scrolls_left = 20;
      fill_phase(PHASE_LEN);
      wait_idle();
    end

    if (fault_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/ttw_pkg.sv
rtl/core/ttw_ram.sv
rtl/core/ttw_datapath.sv
rtl/core/ttw_ctrl.sv
rtl/core/text_terminal_writer.sv
tb/sv/text_terminal_writer_tb.sv
